FILE: src/b32le_pkg.sv
// ----------------------------------------------------------------------------
// b32le_pkg
// Shared types, constants and the table lookup for the base32 label encoder.
// ----------------------------------------------------------------------------
package b32le_pkg;

	localparam int unsigned LabelLengthDefault = 63;
	localparam int unsigned NumCfgRegs         = 4;
	localparam int unsigned CfgIndexWidth      = $clog2(NumCfgRegs);
	localparam int unsigned CfgDataWidth       = 64;
	localparam int unsigned MaxSymbols         = 4;
	localparam int unsigned LabelCountWidth    = 6;

	localparam logic [7:0] SeparatorChar = 8'h2E;

	typedef logic [7:0] char_t;
	// word k, byte j holds table character 8*k + j
	typedef logic [NumCfgRegs-1:0][7:0][7:0] alphabet_t;
	typedef char_t [MaxSymbols-1:0] sym_list_t;

	function automatic char_t table_char(input alphabet_t alpha, input logic [4:0] idx);
		return alpha[idx[4:3]][idx[2:0]];
	endfunction

endpackage

FILE: src/b32le_if.sv
// ----------------------------------------------------------------------------
// b32le_if
// Valid/ready channel interfaces for message bytes and encoded symbols.
// ----------------------------------------------------------------------------
interface b32le_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b32le_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

FILE: src/base32_label_encoder.sv
// The first symbol of a byte is valid in the cycle after the byte's transaction.
// A byte yields one to four symbols, sent one per cycle while sym_out.ready is high; the
//   next byte is taken in the cycle its predecessor's last symbol leaves, so the
//   single-symbol output port sets the pace of a message.
// Reset: arst_n clears the bit buffer, the label count, pending symbols and the table.
// ----------------------------------------------------------------------------
// base32_label_encoder
// LSB-first base32 encoder with a configurable table and '.' label separators.
// ----------------------------------------------------------------------------
module base32_label_encoder
	import b32le_pkg::*;
#(
	parameter int unsigned LABEL_LENGTH = LabelLengthDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	b32le_in_if.sink                 data_in,
	b32le_out_if.source              sym_out
);

	alphabet_t                  alpha_q;
	logic [3:0]                 buf_q;
	logic [2:0]                 bits_q;
	logic [LabelCountWidth-1:0] lc_q;
	sym_list_t                  sym_q;
	logic [2:0]                 cnt_q;
	logic                       end_q;

	logic                       in_acc;
	logic                       out_acc;
	logic [11:0]                packed_bits;
	logic                       two;
	logic [3:0]                 nbuf;
	logic [2:0]                 nbits;
	logic [LabelCountWidth:0]   lc_a;
	logic [LabelCountWidth:0]   lc_b;
	logic                       dot0;
	logic                       dot1;
	logic [LabelCountWidth-1:0] lc_mid;
	logic [LabelCountWidth-1:0] nlc;
	sym_list_t                  nsym;
	logic [2:0]                 ncnt;
	char_t                      flush_char;

	assign in_acc  = data_in.valid && data_in.ready;
	assign out_acc = sym_out.valid && sym_out.ready;

	assign data_in.ready      = (cnt_q == 3'd0) || (cnt_q == 3'd1 && sym_out.ready);
	assign sym_out.valid      = (cnt_q != 3'd0);
	assign sym_out.symbol     = sym_q[0];
	assign sym_out.last_symbol = end_q && (cnt_q == 3'd1);

	assign packed_bits = {8'd0, buf_q} | (12'(data_in.data_byte) << bits_q);
	assign two         = (bits_q >= 3'd2);
	assign nbuf        = two ? {2'b00, packed_bits[11:10]} : packed_bits[8:5];
	assign nbits       = two ? (bits_q - 3'd2) : (bits_q + 3'd3);
	assign flush_char  = table_char(alpha_q, {1'b0, nbuf});

	assign lc_a   = {1'b0, lc_q} + 1'b1;
	assign dot0   = (lc_a == (LabelCountWidth+1)'(LABEL_LENGTH));
	assign lc_mid = dot0 ? '0 : lc_a[LabelCountWidth-1:0];
	assign lc_b   = {1'b0, lc_mid} + 1'b1;
	assign dot1   = (lc_b == (LabelCountWidth+1)'(LABEL_LENGTH));

	always_comb begin
		if (data_in.end_of_message) begin
			nlc = '0;
		end else if (two) begin
			nlc = dot1 ? '0 : lc_b[LabelCountWidth-1:0];
		end else begin
			nlc = lc_mid;
		end
	end

	always_comb begin
		nsym    = '0;
		nsym[0] = table_char(alpha_q, packed_bits[4:0]);
		ncnt    = 3'd1;
		if (dot0) begin
			nsym[ncnt[1:0]] = SeparatorChar;
			ncnt            = ncnt + 3'd1;
		end
		if (two) begin
			nsym[ncnt[1:0]] = table_char(alpha_q, packed_bits[9:5]);
			ncnt            = ncnt + 3'd1;
			if (dot1) begin
				nsym[ncnt[1:0]] = SeparatorChar;
				ncnt            = ncnt + 3'd1;
			end
		end
		if (data_in.end_of_message && nbits != 3'd0) begin
			// a full list loses its trailing separator to the flush character
			if (ncnt == 3'(MaxSymbols)) begin
				nsym[MaxSymbols-1] = flush_char;
			end else begin
				nsym[ncnt[1:0]] = flush_char;
				ncnt            = ncnt + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
		end else if (cfg_we) begin
			alpha_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			bits_q <= '0;
			lc_q   <= '0;
			cnt_q  <= '0;
			end_q  <= 1'b0;
			sym_q  <= '0;
		end else if (in_acc) begin
			buf_q  <= data_in.end_of_message ? '0 : nbuf;
			bits_q <= data_in.end_of_message ? '0 : nbits;
			lc_q   <= nlc;
			cnt_q  <= ncnt;
			end_q  <= data_in.end_of_message;
			sym_q  <= nsym;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 3'd1;
			for (int i = 0; i < MaxSymbols - 1; i++) begin
				sym_q[i] <= sym_q[i+1];
			end
		end
	end

endmodule

FILE: src/b32le_checker.sv
// ----------------------------------------------------------------------------
// b32le_checker
// Port-level checks on the base32 label encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32le_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_symbol,
	input logic       out_last
);

	// nothing pending straight after reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("symbol valid after reset");

	// every byte transaction yields a symbol in the next cycle
	a_byte_gives_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no symbol after byte transaction");

	// an empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending symbol");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_last))
		else $error("stalled symbol changed");

endmodule

bind base32_label_encoder b32le_checker u_b32le_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (data_in.valid),
	.in_ready   (data_in.ready),
	.out_valid  (sym_out.valid),
	.out_ready  (sym_out.ready),
	.out_symbol (sym_out.symbol),
	.out_last   (sym_out.last_symbol)
);

FILE: bench/b32le_symbol_check.sv
// ----------------------------------------------------------------------------
// b32le_symbol_check
// Watches the byte and symbol channels and the table write port of the base32
// label encoder. Predicts the symbols of every accepted byte, queues them and
// compares each symbol transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module b32le_symbol_check
	import b32le_pkg::*;
#(
	parameter int unsigned LabelLength = LabelLengthDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	b32le_in_if                      data_in,
	b32le_out_if                     sym_out,
	output int                       expected_left,
	output int                       mismatch_count
);

	typedef struct packed {
		char_t symbol;
		logic  last_symbol;
	} symbol_txn_t;

	logic [CfgDataWidth-1:0]    table_words [NumCfgRegs];
	logic [11:0]                pend_bits;
	logic [3:0]                 pend_count;
	logic [LabelCountWidth-1:0] label_count;
	symbol_txn_t                pending_symbols [$];

	function automatic char_t table_symbol(input logic [4:0] idx);
		return table_words[idx[4:3]][8*idx[2:0] +: 8];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// one byte in, its symbols onto the queue
	task automatic encode_byte(input char_t data, input logic eom);
		char_t syms [MaxSymbols];
		int    n;
		n = 0;
		pend_bits  = pend_bits | (12'(data) << pend_count);
		pend_count = pend_count + 4'd8;
		while (pend_count >= 4'd5) begin
			if (n < MaxSymbols) begin
				syms[n] = table_symbol(pend_bits[4:0]);
				n++;
			end
			label_count = label_count + 1'b1;
			if (label_count >= LabelLength) begin
				if (n < MaxSymbols) begin
					syms[n] = SeparatorChar;
					n++;
				end
				label_count = '0;
			end
			pend_count = pend_count - 4'd5;
			pend_bits  = pend_bits >> 5;
		end
		if (eom) begin
			// flush of the leftover bits; on a full list it displaces the separator
			if (pend_count != 0) begin
				if (n >= MaxSymbols)
					n = MaxSymbols - 1;
				syms[n] = table_symbol(pend_bits[4:0]);
				n++;
			end
			pend_bits   = '0;
			pend_count  = '0;
			label_count = '0;
		end
		for (int k = 0; k < n; k++)
			pending_symbols.push_back(symbol_txn_t'{syms[k], eom && (k == n - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		symbol_txn_t want;
		if (!arst_n) begin
			for (int k = 0; k < NumCfgRegs; k++)
				table_words[k] = '0;
			pend_bits   = '0;
			pend_count  = '0;
			label_count = '0;
			pending_symbols.delete();
			mismatch_count = 0;
			expected_left <= 0;
		end else begin
			if (cfg_we)
				table_words[cfg_index] = cfg_data;
			if (data_in.valid && data_in.ready)
				encode_byte(data_in.data_byte, data_in.end_of_message);
			if (sym_out.valid && sym_out.ready) begin
				if (pending_symbols.size() == 0) begin
					report_mismatch($sformatf("symbol 0x%02h with nothing predicted",
						sym_out.symbol));
				end else begin
					want = pending_symbols.pop_front();
					if (sym_out.symbol !== want.symbol)
						report_mismatch($sformatf("symbol 0x%02h, predicted 0x%02h",
							sym_out.symbol, want.symbol));
					if (sym_out.last_symbol !== want.last_symbol)
						report_mismatch($sformatf("last_symbol %b, predicted %b on 0x%02h",
							sym_out.last_symbol, want.last_symbol, want.symbol));
				end
			end
			expected_left <= pending_symbols.size();
		end
	end

endmodule

FILE: bench/base32_label_encoder_tb.sv
// ----------------------------------------------------------------------------
// base32_label_encoder_tb
// Drives message bytes and table writes into the base32 label encoder under
// varying stalls on both channels: a directed set of short messages, then
// random messages in three table settings, one of them ending on a separator.
// Checking is done by b32le_symbol_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module base32_label_encoder_tb;
	import b32le_pkg::*;

	// set LabelLength to 1 to reach the dropped separator before a flush
	parameter int unsigned LabelLength = LabelLengthDefault;

	localparam int StallLimit  = 2000;
	localparam int PhaseItems  = 18;
	localparam int Holdoff     = 4;
	localparam int NumDirected = 16;

	localparam char_t DirectedBytes [NumDirected] = '{
		8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'hFF,
		8'h00, 8'h5A, 8'hA5, 8'h0F, 8'h00, 8'hFF, 8'h80, 8'h01
	};
	// message lengths 1, 1, 5 (no flush), 2, 3, 4
	localparam bit DirectedEnd [NumDirected] = '{
		1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;
	int                       send_idle_pct = 0;
	int                       recv_idle_pct = 0;
	int                       items_sent    = 0;
	int                       expected_left;
	int                       mismatch_count;
	int                       idle_run;
	alphabet_t                tbl;
	string                    letters = "abcdefghijklmnopqrstuvwxyz234567";

	b32le_in_if  byte_ch ();
	b32le_out_if sym_ch ();

	base32_label_encoder #(
		.LABEL_LENGTH(LabelLength)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.data_in  (byte_ch),
		.sym_out  (sym_ch)
	);

	b32le_symbol_check #(
		.LabelLength(LabelLength)
	) symbol_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_in       (byte_ch),
		.sym_out       (sym_ch),
		.expected_left (expected_left),
		.mismatch_count(mismatch_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		sym_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic alphabet_t random_table();
		alphabet_t t;
		for (int k = 0; k < NumCfgRegs; k++)
			t[k] = {$urandom, $urandom};
		return t;
	endfunction

	function automatic char_t pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return char_t'($urandom_range(255));
	endfunction

	// bytes in a message whose character count is a whole number of labels
	// and of bytes, so that it ends on a separator with nothing to flush
	function automatic int dot_end_bytes();
		int chars;
		chars = LabelLength;
		while (chars % 8 != 0)
			chars += LabelLength;
		return chars * 5 / 8;
	endfunction

	task automatic load_table(input alphabet_t t);
		for (int k = 0; k < NumCfgRegs; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CfgIndexWidth'(k);
			cfg_data  <= t[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input char_t data, input logic eom);
		if ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		byte_ch.valid          <= 1'b1;
		byte_ch.data_byte      <= data;
		byte_ch.end_of_message <= eom;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(), i == len - 1);
	endtask

	task automatic wait_drained(input int extra);
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic random_traffic(input int n_items);
		int goal;
		int len;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(19) == 0)
				wait_drained(0);
			if ($urandom_range(3) == 0)
				len = $urandom_range(90, 13);
			else
				len = $urandom_range(12, 1);
			send_message(len);
		end
	endtask

	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_data               <= '0;
		byte_ch.valid          <= 1'b0;
		byte_ch.data_byte      <= '0;
		byte_ch.end_of_message <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 32; i++)
			tbl[i / 8][i % 8] = letters[i];
		load_table(tbl);
		for (int i = 0; i < NumDirected; i++)
			send_byte(DirectedBytes[i], DirectedEnd[i]);
		wait_drained(Holdoff);

		send_idle_pct = 30;
		recv_idle_pct <= 50;
		load_table(random_table());
		random_traffic(PhaseItems);
		wait_drained(Holdoff);

		send_idle_pct = 50;
		recv_idle_pct <= 30;
		tbl = random_table();
		tbl[0] = '0;
		tbl[NumCfgRegs-1] = '1;
		load_table(tbl);
		random_traffic(PhaseItems);
		wait_drained(Holdoff);

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		tbl = random_table();
		tbl[0] = '1;
		tbl[NumCfgRegs-1] = '0;
		load_table(tbl);
		random_traffic(PhaseItems);
		send_message(dot_end_bytes());
		wait_drained(8);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// no transaction on either channel for too long
	initial begin
		idle_run = 0;
		while (idle_run < StallLimit) begin
			@(posedge clk);
			if (!arst_n || (byte_ch.valid && byte_ch.ready) || (sym_ch.valid && sym_ch.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
src/b32le_pkg.sv
src/b32le_if.sv
src/base32_label_encoder.sv
src/b32le_checker.sv
bench/b32le_symbol_check.sv
bench/base32_label_encoder_tb.sv
